### hw/rtl/sbd_pkg.sv
package sbd_pkg;

    localparam int VALUE_WIDTH = 64;
    // decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
    localparam int DIGITS      = 19;
    localparam int BCD_WIDTH   = DIGITS * 4;
    localparam int DIGIT_WIDTH = 4;
    localparam int POS_WIDTH   = 5;
    localparam int ITER_WIDTH  = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] mag_t;
    typedef logic [BCD_WIDTH-1:0]   bcd_t;
    typedef logic [POS_WIDTH-1:0]   pos_t;

    typedef struct packed {
        logic neg;
        mag_t mag;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } queue_head_t;

    typedef struct packed {
        logic valid;
        logic neg;
        pos_t count;
        bcd_t bcd;
    } conv_result_t;

endpackage

### hw/rtl/sbd_front.sv
module sbd_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [63:0]                value,
    output logic                       busy,
    output sbd_pkg::queue_head_t       head,
    input  logic                       pop
);

    sbd_pkg::job_t queue_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg,   fill_next;

    sbd_pkg::mag_t low_bits;
    sbd_pkg::job_t job_in;
    logic          push;
    logic          take;

    // drop bits above the configured width, then take the magnitude
    always_comb
    begin
        low_bits   = value[sbd_pkg::VALUE_WIDTH-1:0];
        job_in.neg = low_bits[sbd_pkg::VALUE_WIDTH-1];
        job_in.mag = job_in.neg ? (~low_bits + sbd_pkg::mag_t'(1)) : low_bits;
    end

    assign busy       = fill_reg[1];
    assign push       = start && !busy;
    assign head.valid = (fill_reg != 2'd0);
    assign head.job   = queue_reg[rd_ptr_reg];
    assign take       = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !take)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (take && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

### hw/rtl/sbd_convert.sv
module sbd_convert (
    input  logic                       clk,
    input  logic                       rst_n,
    input  sbd_pkg::queue_head_t       head,
    output logic                       pop,
    output sbd_pkg::conv_result_t      result,
    input  logic                       result_take
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_HOLD
    } state_t;

    state_t                          state_reg, state_next;
    sbd_pkg::mag_t                   shift_reg, shift_next;
    sbd_pkg::bcd_t                   bcd_reg,   bcd_next;
    logic                            neg_reg,   neg_next;
    logic [sbd_pkg::ITER_WIDTH-1:0]  iter_reg,  iter_next;

    sbd_pkg::bcd_t adjusted;
    sbd_pkg::pos_t count;

    // add 3 to every digit of 5 or more ahead of the shift
    always_comb
    begin
        for (int i = 0; i < sbd_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
            begin
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end
            else
            begin
                adjusted[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    // highest nonzero digit sets the count
    always_comb
    begin
        count = '0;
        for (int i = 0; i < sbd_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
            begin
                count = sbd_pkg::POS_WIDTH'(i + 1);
            end
        end
    end

    assign result.valid = (state_reg == ST_HOLD);
    assign result.neg   = neg_reg;
    assign result.count = count;
    assign result.bcd   = bcd_reg;

    always_comb
    begin
        state_next = state_reg;
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        iter_next  = iter_reg;
        pop        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop        = 1'b1;
                    shift_next = head.job.mag;
                    neg_next   = head.job.neg;
                    bcd_next   = '0;
                    iter_next  = '0;
                    state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                bcd_next   = {adjusted[sbd_pkg::BCD_WIDTH-2:0],
                              shift_reg[sbd_pkg::VALUE_WIDTH-1]};
                shift_next = {shift_reg[sbd_pkg::VALUE_WIDTH-2:0], 1'b0};
                iter_next  = iter_reg + 1'b1;
                if (iter_reg == sbd_pkg::ITER_WIDTH'(sbd_pkg::VALUE_WIDTH - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (result_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            shift_reg <= '0;
            bcd_reg   <= '0;
            neg_reg   <= 1'b0;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            shift_reg <= shift_next;
            bcd_reg   <= bcd_next;
            neg_reg   <= neg_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

### hw/rtl/sbd_emit.sv
module sbd_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sbd_pkg::conv_result_t         result,
    output logic                          result_take,
    output logic                          strobe,
    output logic [sbd_pkg::DIGIT_WIDTH-1:0] digit,
    output sbd_pkg::pos_t                 position,
    output logic                          negative,
    output sbd_pkg::pos_t                 digit_count,
    output logic                          last
);

    logic          active_reg, active_next;
    sbd_pkg::bcd_t bcd_reg,    bcd_next;
    sbd_pkg::pos_t pos_reg,    pos_next;
    sbd_pkg::pos_t count_reg,  count_next;
    logic          neg_reg,    neg_next;

    logic                             strobe_reg, strobe_next;
    logic [sbd_pkg::DIGIT_WIDTH-1:0]  digit_reg,  digit_next;
    sbd_pkg::pos_t                    opos_reg,   opos_next;
    logic                             oneg_reg,   oneg_next;
    sbd_pkg::pos_t                    ocount_reg, ocount_next;
    logic                             last_reg,   last_next;

    logic final_digit;

    assign result_take = result.valid && !active_reg;
    // zero still gives one transaction
    assign final_digit = (count_reg == '0) || (pos_reg == count_reg - sbd_pkg::pos_t'(1));

    always_comb
    begin
        active_next = active_reg;
        bcd_next    = bcd_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        neg_next    = neg_reg;
        strobe_next = 1'b0;
        digit_next  = digit_reg;
        opos_next   = opos_reg;
        oneg_next   = oneg_reg;
        ocount_next = ocount_reg;
        last_next   = last_reg;
        if (active_reg)
        begin
            strobe_next = 1'b1;
            digit_next  = bcd_reg[sbd_pkg::DIGIT_WIDTH-1:0];
            opos_next   = pos_reg;
            oneg_next   = neg_reg;
            ocount_next = count_reg;
            last_next   = final_digit;
            bcd_next    = bcd_reg >> sbd_pkg::DIGIT_WIDTH;
            pos_next    = pos_reg + sbd_pkg::pos_t'(1);
            active_next = !final_digit;
        end
        else if (result.valid)
        begin
            active_next = 1'b1;
            bcd_next    = result.bcd;
            pos_next    = '0;
            count_next  = result.count;
            neg_next    = result.neg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg    <= bcd_next;
        pos_reg    <= pos_next;
        count_reg  <= count_next;
        neg_reg    <= neg_next;
        digit_reg  <= digit_next;
        opos_reg   <= opos_next;
        oneg_reg   <= oneg_next;
        ocount_reg <= ocount_next;
        last_reg   <= last_next;
    end

    assign strobe      = strobe_reg;
    assign digit       = digit_reg;
    assign position    = opos_reg;
    assign negative    = oneg_reg;
    assign digit_count = ocount_reg;
    assign last        = last_reg;

endmodule

### hw/rtl/signed_binary_to_decimal_digits_top.sv
// Channel   Handshake                 Payload
// input     start / busy              value[63:0] (signed)
// result    strobe (one cycle each)   digit[3:0] position[4:0] negative
//                                     digit_count[4:0] last
//
// An item passes the bit-serial double dabble converter at one input bit per
// cycle, after a pop from the queue, and is then handed off to the emitter.
// Digits leave one per cycle, up to 19 per item, while the next item converts.
// A two-entry queue sits between input and converter; busy is high while full.
// Reset empties the queue and drops any item in flight; no clearing pass.
// Results are never held off by the receiver.
module signed_binary_to_decimal_digits_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] value,
    output logic        busy,
    output logic        strobe,
    output logic [3:0]  digit,
    output logic [4:0]  position,
    output logic        negative,
    output logic [4:0]  digit_count,
    output logic        last
);

    sbd_pkg::queue_head_t  head;
    logic                  pop;
    sbd_pkg::conv_result_t result;
    logic                  result_take;

    sbd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (value),
        .busy  (busy),
        .head  (head),
        .pop   (pop)
    );

    sbd_convert u_convert (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .result      (result),
        .result_take (result_take)
    );

    sbd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .result      (result),
        .result_take (result_take),
        .strobe      (strobe),
        .digit       (digit),
        .position    (position),
        .negative    (negative),
        .digit_count (digit_count),
        .last        (last)
    );

endmodule

### hw/rtl/sbd_checker.sv
module sbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       strobe,
    input logic [3:0] digit,
    input logic [4:0] position,
    input logic       negative,
    input logic [4:0] digit_count,
    input logic       last
);

    // final transaction sits at the top position of the run
    a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last && (digit_count != 5'd0) |-> position == digit_count - 5'd1)
        else $error("last digit position does not match digit count");

    // a run is emitted without gaps, position rising by one
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe && (position == $past(position) + 5'd1)
            && $stable(digit_count) && $stable(negative))
        else $error("digit run broken");

    // zero gives one transaction only
    a_zero_item: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (digit_count == 5'd0) |-> last && (digit == 4'd0) && !negative
            && (position == 5'd0))
        else $error("zero result malformed");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (digit <= 4'd9) && (digit_count <= 5'd19))
        else $error("digit or count out of range");

    // top digit of a run is never zero
    a_leading_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last && (digit_count != 5'd0) |-> digit != 4'd0)
        else $error("leading digit is zero");

endmodule

bind signed_binary_to_decimal_digits_top sbd_checker u_sbd_checker (.*);
